FILE: rtl/core/plist_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by positional_list_engine.
package plist_pkg;

  // Field widths of the request and result transfers
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned POSITION_W = 7;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned INDEX_W    = 7;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEFAULT      = 64;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT       = 3'd0,
    ACT_REMOVE_AT    = 3'd1,
    ACT_READ         = 3'd2,
    ACT_FIND         = 3'd3,
    ACT_REMOVE_VALUE = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_RD_WAIT,
    ST_DEL_SHIFT,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/plist_ram.sv
// Simple dual-port list storage: one write port, one registered read port.
// Depends on nothing; instantiated by positional_list_engine.
module plist_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read: rdata shows the word at raddr in the cycle after
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/positional_list_engine.sv
// Positional list engine top level: request decode, walk sequencer, result register.
// Depends on plist_pkg and plist_ram.
//
// Usage:
//   Request channel (in_valid/in_ready): action, position, value. One request
//   is worked on at a time; in_ready is high only while the sequencer is idle.
//   Result channel (out_valid/out_ready): data, found_index, count, error,
//   exactly one result per request, held in an output register.
//   Steps: an insert at p moves entries c - 1 down to p (c the count) up by
//   one, then writes the value (p == c: the write alone); a remove at p reads
//   entry p, then moves those above it down by one; a read waits for the
//   registered read; find / remove value scan up from entry 0 to a match or
//   the last entry (a miss scans all); refusals end at once. The single list
//   memory moves or scans one entry per cycle via its one read and one write port.
//   While the receiver stalls, a finished result waits in the output register
//   and the next request is still taken and worked on; it holds in its final
//   step until the register frees up.
//   Reset (rst, synchronous) empties the list and drops any pending result.
//   Entry storage is not cleared; only entries below the count are ever read.
module positional_list_engine #(
  parameter int unsigned DEPTH      = plist_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = plist_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plist_pkg::ACTION_W-1:0]    action,
  input  logic [plist_pkg::POSITION_W-1:0]  position,
  input  logic [plist_pkg::VALUE_W-1:0]     value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [plist_pkg::DATA_W-1:0]      data,
  output logic [plist_pkg::INDEX_W-1:0]     found_index,
  output logic [plist_pkg::INDEX_W-1:0]     count,
  output logic                              error
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  plist_pkg::state_t  state, state_next;
  plist_pkg::action_t act, act_next;

  logic [CW-1:0]         cnt, cnt_next;          // entries stored
  logic [AW-1:0]         idx, idx_next;          // address of the read in flight
  logic [AW-1:0]         pos, pos_next;          // insert target
  logic [DATA_WIDTH-1:0] val, val_next;          // value to insert or match
  logic                  first, first_next;      // first read of a removal

  // pending result
  logic [DATA_WIDTH-1:0] res_data, res_data_next;
  logic [CW-1:0]         res_found, res_found_next;
  logic [CW-1:0]         res_count, res_count_next;
  logic                  res_err, res_err_next;

  // memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  plist_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Request decode helpers
  // ---------------------------------------------------------------------------
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] value_in;               // value kept to DATA_WIDTH bits
  logic [15:0]           pos_w, cnt_w;
  logic                  list_full, list_empty;
  logic                  idx_is_last;            // read in flight is the last entry
  logic                  in_xfer, out_xfer;

  assign value_ext   = {32'd0, value};
  assign value_in    = value_ext[DATA_WIDTH-1:0];
  assign pos_w       = 16'(position);
  assign cnt_w       = 16'(cnt);
  assign list_full   = (cnt_w == 16'(DEPTH));
  assign list_empty  = (cnt == '0);
  assign idx_is_last = ((CW'(idx) + CW'(1)) == cnt);

  assign in_ready = (state == plist_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, memory control, datapath updates
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    act_next       = act;
    cnt_next       = cnt;
    idx_next       = idx;
    pos_next       = pos;
    val_next       = val;
    first_next     = first;
    res_data_next  = res_data;
    res_found_next = res_found;
    res_count_next = res_count;
    res_err_next   = res_err;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = mem_rdata;
    mem_raddr      = idx;

    case (state)
      plist_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_next       = plist_pkg::action_t'(action);
          val_next       = value_in;
          pos_next       = position[AW-1:0] & {AW{1'b1}};
          res_data_next  = '0;
          res_found_next = '0;
          res_count_next = cnt;
          res_err_next   = 1'b0;
          state_next     = plist_pkg::ST_FINISH;
          case (plist_pkg::action_t'(action))
            plist_pkg::ACT_INSERT: begin
              if (list_full || (pos_w > cnt_w)) begin
                res_err_next = 1'b1;
              end else if (pos_w == cnt_w) begin
                pos_next   = cnt[AW-1:0];
                state_next = plist_pkg::ST_INS_WRITE;
              end else begin
                // walk down from the top entry, moving each one up
                pos_next   = pos_w[AW-1:0];
                idx_next   = AW'(cnt - CW'(1));
                mem_raddr  = AW'(cnt - CW'(1));
                state_next = plist_pkg::ST_INS_SHIFT;
              end
            end
            plist_pkg::ACT_REMOVE_AT: begin
              if (pos_w >= cnt_w) begin
                res_err_next = 1'b1;
              end else begin
                idx_next   = pos_w[AW-1:0];
                mem_raddr  = pos_w[AW-1:0];
                first_next = 1'b1;
                state_next = plist_pkg::ST_DEL_SHIFT;
              end
            end
            plist_pkg::ACT_READ: begin
              if (pos_w >= cnt_w) begin
                res_err_next = 1'b1;
              end else begin
                mem_raddr  = pos_w[AW-1:0];
                state_next = plist_pkg::ST_RD_WAIT;
              end
            end
            plist_pkg::ACT_FIND, plist_pkg::ACT_REMOVE_VALUE: begin
              if (list_empty) begin
                res_err_next = 1'b1;
                if (plist_pkg::action_t'(action) == plist_pkg::ACT_FIND) begin
                  res_found_next = cnt;
                end
              end else begin
                idx_next   = '0;
                mem_raddr  = '0;
                state_next = plist_pkg::ST_SCAN;
              end
            end
            default: begin
              res_err_next = 1'b1;
            end
          endcase
        end
      end

      plist_pkg::ST_INS_SHIFT: begin
        // entry idx arrives; it moves to idx + 1
        mem_we    = 1'b1;
        mem_waddr = idx + AW'(1);
        mem_wdata = mem_rdata;
        if (idx == pos) begin
          state_next = plist_pkg::ST_INS_WRITE;
        end else begin
          idx_next  = idx - AW'(1);
          mem_raddr = idx - AW'(1);
        end
      end

      plist_pkg::ST_INS_WRITE: begin
        mem_we         = 1'b1;
        mem_waddr      = pos;
        mem_wdata      = val;
        cnt_next       = cnt + CW'(1);
        res_count_next = cnt + CW'(1);
        state_next     = plist_pkg::ST_FINISH;
      end

      plist_pkg::ST_RD_WAIT: begin
        res_data_next = mem_rdata;
        state_next    = plist_pkg::ST_FINISH;
      end

      plist_pkg::ST_DEL_SHIFT: begin
        // first read returns the removed entry; later ones move down by one
        if (first) begin
          res_data_next = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (idx_is_last) begin
          cnt_next       = cnt - CW'(1);
          res_count_next = cnt - CW'(1);
          state_next     = plist_pkg::ST_FINISH;
        end else begin
          first_next = 1'b0;
          idx_next   = idx + AW'(1);
          mem_raddr  = idx + AW'(1);
        end
      end

      plist_pkg::ST_SCAN: begin
        if (mem_rdata == val) begin
          if (act == plist_pkg::ACT_FIND) begin
            res_found_next = CW'(idx);
            state_next     = plist_pkg::ST_FINISH;
          end else begin
            // matched entry already read: go on as a removal at idx
            res_data_next = mem_rdata;
            if (idx_is_last) begin
              cnt_next       = cnt - CW'(1);
              res_count_next = cnt - CW'(1);
              state_next     = plist_pkg::ST_FINISH;
            end else begin
              first_next = 1'b0;
              idx_next   = idx + AW'(1);
              mem_raddr  = idx + AW'(1);
              state_next = plist_pkg::ST_DEL_SHIFT;
            end
          end
        end else if (idx_is_last) begin
          res_err_next = 1'b1;
          if (act == plist_pkg::ACT_FIND) begin
            res_found_next = cnt;
          end
          state_next = plist_pkg::ST_FINISH;
        end else begin
          idx_next  = idx + AW'(1);
          mem_raddr = idx + AW'(1);
        end
      end

      plist_pkg::ST_FINISH: begin
        // result moves to the output register once it is free
        if (!out_valid || out_ready) begin
          state_next = plist_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = plist_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plist_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    idx       <= idx_next;
    pos       <= pos_next;
    val       <= val_next;
    first     <= first_next;
    res_data  <= res_data_next;
    res_found <= res_found_next;
    res_count <= res_count_next;
    res_err   <= res_err_next;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic        load_out;
  logic [63:0] data_ext;
  logic [15:0] found_ext, count_ext;

  assign load_out  = (state == plist_pkg::ST_FINISH) && (!out_valid || out_ready);
  assign data_ext  = 64'(res_data);
  assign found_ext = 16'(res_found);
  assign count_ext = 16'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data        <= data_ext[plist_pkg::DATA_W-1:0];
      found_index <= found_ext[plist_pkg::INDEX_W-1:0];
      count       <= count_ext[plist_pkg::INDEX_W-1:0];
      error       <= res_err;
    end
  end

endmodule
